### rtl/core/ffs_pkg.sv
`timescale 1ns / 1ps

package ffs_pkg;

    typedef logic [31:0] fp32_t;

    localparam fp32_t SEED_MAGIC   = 32'h5f3759df;
    localparam fp32_t HALF         = 32'h3f000000;
    localparam fp32_t THREE_HALVES = 32'h3fc00000;
    localparam fp32_t DEFAULT_NAN  = 32'hffc00000;
    localparam fp32_t QUIET_BIT    = 32'h00400000;

    // pipeline depth of the float units and of one refinement cell
    localparam int MUL_LAT  = 3;
    localparam int SUB_LAT  = 3;
    localparam int CELL_LAT = 3 * MUL_LAT + SUB_LAT;

    function automatic logic [4:0] clz24(input logic [23:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) r = 5'(23 - i);
        end
        return r;
    endfunction

    function automatic logic [4:0] clz27(input logic [26:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) r = 5'(26 - i);
        end
        return r;
    endfunction

endpackage

### rtl/core/ffs_fmul.sv
`timescale 1ns / 1ps

module ffs_fmul (
    input  logic          aclk,
    input  logic          en,
    input  ffs_pkg::fp32_t a,
    input  ffs_pkg::fp32_t b,
    output ffs_pkg::fp32_t y
);
    import ffs_pkg::*;

    // stage 1: unpack, specials, pre-normalize subnormals
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic        spec;
    fp32_t       spec_val;
    logic [23:0] ma0, mb0;
    logic [4:0]  lza, lzb;
    logic signed [9:0] exa, exb;

    always_comb begin
        ea = a[30:23]; fa = a[22:0];
        eb = b[30:23]; fb = b[22:0];
        a_nan  = (ea == 8'hff) && (fa != 23'd0);
        b_nan  = (eb == 8'hff) && (fb != 23'd0);
        a_inf  = (ea == 8'hff) && (fa == 23'd0);
        b_inf  = (eb == 8'hff) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        sgn    = a[31] ^ b[31];
        spec     = 1'b1;
        spec_val = '0;
        if (a_nan) begin
            spec_val = a | QUIET_BIT;
        end else if (b_nan) begin
            spec_val = b | QUIET_BIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_val = DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            spec_val = {sgn, 8'hff, 23'd0};
        end else if (a_zero || b_zero) begin
            spec_val = {sgn, 31'd0};
        end else begin
            spec = 1'b0;
        end
        ma0 = {ea != 8'd0, fa};
        mb0 = {eb != 8'd0, fb};
        lza = clz24(ma0);
        lzb = clz24(mb0);
        exa = ((ea == 8'd0) ? 10'sd1 : $signed({2'b00, ea})) - $signed({5'd0, lza});
        exb = ((eb == 8'd0) ? 10'sd1 : $signed({2'b00, eb})) - $signed({5'd0, lzb});
    end

    logic        s1_spec_reg, s1_sgn_reg;
    fp32_t       s1_val_reg;
    logic [23:0] s1_ma_reg, s1_mb_reg;
    logic signed [9:0] s1_ea_reg, s1_eb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_spec_reg <= spec;
            s1_val_reg  <= spec_val;
            s1_sgn_reg  <= sgn;
            s1_ma_reg   <= ma0 << lza;
            s1_mb_reg   <= mb0 << lzb;
            s1_ea_reg   <= exa;
            s1_eb_reg   <= exb;
        end
    end

    // stage 2: mantissa product
    logic        s2_spec_reg, s2_sgn_reg;
    fp32_t       s2_val_reg;
    logic [47:0] s2_prod_reg;
    logic signed [9:0] s2_exp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_spec_reg <= s1_spec_reg;
            s2_val_reg  <= s1_val_reg;
            s2_sgn_reg  <= s1_sgn_reg;
            s2_prod_reg <= s1_ma_reg * s1_mb_reg;
            s2_exp_reg  <= s1_ea_reg + s1_eb_reg - 10'sd127;
        end
    end

    // stage 3: normalize, denormalize on underflow, round to nearest even
    logic [47:0] norm, shifted, lost_mask;
    logic signed [9:0] e, diff;
    logic [5:0]  sh;
    logic        lost, g, st, rnd;
    logic [7:0]  exp_field;
    logic [30:0] packed_res;
    fp32_t       res;

    always_comb begin
        norm = s2_prod_reg[47] ? s2_prod_reg : (s2_prod_reg << 1);
        e    = s2_exp_reg + (s2_prod_reg[47] ? 10'sd1 : 10'sd0);
        diff = 10'sd1 - e;
        if (e >= 10'sd1) begin
            sh = 6'd0;
        end else if (diff > 10'sd48) begin
            sh = 6'd48;
        end else begin
            sh = diff[5:0];
        end
        shifted   = norm >> sh;
        lost_mask = ~({48{1'b1}} << sh);
        lost      = |(norm & lost_mask);
        g         = shifted[23];
        st        = (|shifted[22:0]) | lost;
        rnd       = g & (st | shifted[24]);
        exp_field = (e >= 10'sd1) ? e[7:0] : 8'd0;
        packed_res = {exp_field, shifted[46:24]} + {30'd0, rnd};
        if (e >= 10'sd255) begin
            res = {s2_sgn_reg, 8'hff, 23'd0};
        end else begin
            res = {s2_sgn_reg, packed_res};
        end
    end

    fp32_t y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= s2_spec_reg ? s2_val_reg : res;
        end
    end

    assign y = y_reg;

endmodule

### rtl/core/ffs_fsub.sv
`timescale 1ns / 1ps

module ffs_fsub (
    input  logic          aclk,
    input  logic          en,
    input  ffs_pkg::fp32_t a,
    input  ffs_pkg::fp32_t b,
    output ffs_pkg::fp32_t y
);
    import ffs_pkg::*;

    // stage 1: unpack, specials, order by magnitude (computes a - b)
    logic [7:0]  ea, eb, e_big, e_small;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, a_big;
    logic        spec;
    fp32_t       spec_val;
    logic [23:0] m_big, m_small;

    always_comb begin
        ea = a[30:23]; fa = a[22:0];
        eb = b[30:23]; fb = b[22:0];
        sbe    = ~b[31];
        a_nan  = (ea == 8'hff) && (fa != 23'd0);
        b_nan  = (eb == 8'hff) && (fb != 23'd0);
        a_inf  = (ea == 8'hff) && (fa == 23'd0);
        b_inf  = (eb == 8'hff) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        spec     = 1'b1;
        spec_val = '0;
        if (a_nan) begin
            spec_val = a | QUIET_BIT;
        end else if (b_nan) begin
            spec_val = b | QUIET_BIT;
        end else if (a_inf && b_inf && (a[31] != sbe)) begin
            spec_val = DEFAULT_NAN;
        end else if (a_inf) begin
            spec_val = a;
        end else if (b_inf) begin
            spec_val = {sbe, 8'hff, 23'd0};
        end else if (a_zero && b_zero) begin
            spec_val = {a[31] & sbe, 31'd0};
        end else begin
            spec = 1'b0;
        end
        a_big   = a[30:0] >= b[30:0];
        e_big   = a_big ? ea : eb;
        e_small = a_big ? eb : ea;
        m_big   = a_big ? {ea != 8'd0, fa} : {eb != 8'd0, fb};
        m_small = a_big ? {eb != 8'd0, fb} : {ea != 8'd0, fa};
        if (e_big == 8'd0) e_big = 8'd1;
        if (e_small == 8'd0) e_small = 8'd1;
    end

    logic        s1_spec_reg, s1_sgn_reg, s1_sub_reg;
    fp32_t       s1_val_reg;
    logic [23:0] s1_mbig_reg, s1_msmall_reg;
    logic [7:0]  s1_exp_reg, s1_d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_spec_reg   <= spec;
            s1_val_reg    <= spec_val;
            s1_sgn_reg    <= a_big ? a[31] : sbe;
            s1_sub_reg    <= a[31] ^ sbe;
            s1_mbig_reg   <= m_big;
            s1_msmall_reg <= m_small;
            s1_exp_reg    <= e_big;
            s1_d_reg      <= e_big - e_small;
        end
    end

    // stage 2: align the smaller operand with sticky, add or subtract
    logic [26:0] bfull, bs, lost_mask;
    logic [4:0]  sh;
    logic [27:0] aa, bb;
    logic        lost;

    always_comb begin
        bfull     = {s1_msmall_reg, 3'b000};
        sh        = (s1_d_reg > 8'd27) ? 5'd27 : s1_d_reg[4:0];
        bs        = bfull >> sh;
        lost_mask = ~({27{1'b1}} << sh);
        lost      = |(bfull & lost_mask);
        aa        = {1'b0, s1_mbig_reg, 3'b000};
        bb        = {1'b0, bs[26:1], bs[0] | lost};
    end

    logic        s2_spec_reg, s2_sgn_reg;
    fp32_t       s2_val_reg;
    logic [27:0] s2_sum_reg;
    logic [7:0]  s2_exp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_spec_reg <= s1_spec_reg;
            s2_val_reg  <= s1_val_reg;
            s2_sgn_reg  <= s1_sgn_reg;
            s2_exp_reg  <= s1_exp_reg;
            s2_sum_reg  <= s1_sub_reg ? (aa - bb) : (aa + bb);
        end
    end

    // stage 3: normalize (never below the smallest exponent) and round
    logic [26:0] r;
    logic [8:0]  e, max_sh, shl;
    logic [4:0]  lz;
    logic        g, st, rnd;
    logic [7:0]  exp_field;
    logic [30:0] packed_res;
    fp32_t       res;

    always_comb begin
        lz     = clz27(s2_sum_reg[26:0]);
        max_sh = {1'b0, s2_exp_reg} - 9'd1;
        shl    = ({4'd0, lz} < max_sh) ? {4'd0, lz} : max_sh;
        if (s2_sum_reg[27]) begin
            r = {s2_sum_reg[27:2], s2_sum_reg[1] | s2_sum_reg[0]};
            e = {1'b0, s2_exp_reg} + 9'd1;
        end else begin
            r = s2_sum_reg[26:0] << shl;
            e = {1'b0, s2_exp_reg} - shl;
        end
        g   = r[2];
        st  = r[1] | r[0];
        rnd = g & (st | r[3]);
        exp_field  = r[26] ? e[7:0] : 8'd0;
        packed_res = {exp_field, r[25:3]} + {30'd0, rnd};
        if (s2_sum_reg == 28'd0) begin
            res = 32'd0;
        end else if (e >= 9'd255) begin
            res = {s2_sgn_reg, 8'hff, 23'd0};
        end else begin
            res = {s2_sgn_reg, packed_res};
        end
    end

    fp32_t y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= s2_spec_reg ? s2_val_reg : res;
        end
    end

    assign y = y_reg;

endmodule

### rtl/core/ffs_newton_cell.sv
`timescale 1ns / 1ps

module ffs_newton_cell (
    input  logic          aclk,
    input  logic          en,
    input  ffs_pkg::fp32_t x_in,
    input  ffs_pkg::fp32_t h_in,
    input  ffs_pkg::fp32_t y_in,
    output ffs_pkg::fp32_t x_out,
    output ffs_pkg::fp32_t h_out,
    output ffs_pkg::fp32_t y_out
);
    import ffs_pkg::*;

    localparam int YD = 2 * MUL_LAT + SUB_LAT;

    fp32_t x_pipe_reg [CELL_LAT];
    fp32_t h_pipe_reg [CELL_LAT];
    fp32_t y_pipe_reg [YD];
    fp32_t t1, t2, t3;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_pipe_reg[0] <= x_in;
            h_pipe_reg[0] <= h_in;
            y_pipe_reg[0] <= y_in;
            for (int i = 1; i < CELL_LAT; i++) begin
                x_pipe_reg[i] <= x_pipe_reg[i-1];
                h_pipe_reg[i] <= h_pipe_reg[i-1];
            end
            for (int i = 1; i < YD; i++) begin
                y_pipe_reg[i] <= y_pipe_reg[i-1];
            end
        end
    end

    // y * (1.5 - (h*y)*y)
    ffs_fmul u_hy  (.aclk(aclk), .en(en), .a(h_in), .b(y_in), .y(t1));
    ffs_fmul u_hyy (.aclk(aclk), .en(en), .a(t1), .b(y_pipe_reg[MUL_LAT-1]), .y(t2));
    ffs_fsub u_sub (.aclk(aclk), .en(en), .a(THREE_HALVES), .b(t2), .y(t3));
    ffs_fmul u_upd (.aclk(aclk), .en(en), .a(y_pipe_reg[YD-1]), .b(t3), .y(y_out));

    assign x_out = x_pipe_reg[CELL_LAT-1];
    assign h_out = h_pipe_reg[CELL_LAT-1];

endmodule

### rtl/core/fast_float_sqrt.sv
`timescale 1ns / 1ps

// approximate binary32 square root: the operand bits, read as a signed integer and shifted
// right by one, are subtracted from 0x5f3759df to seed 1/sqrt(x); NEWTON_STEPS cells then
// refine the seed with y = y*(1.5 - (h*y)*y), h = x*0.5, and the result is x*y. every float
// operation rounds to nearest even with gradual underflow; nan and infinity simply flow
// through the arithmetic. one operand is taken per cycle unless the output stalls. the
// datapath is a chain of three-stage float units: one multiply for h, four operations per
// refinement cell, one final multiply. the whole pipe advances together and only holds while
// a finished result waits on m_ready.

module fast_float_sqrt #(
    parameter int NEWTON_STEPS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_root_bits
);
    import ffs_pkg::*;

    localparam int LAT = 2 * MUL_LAT + NEWTON_STEPS * CELL_LAT;

    // global advance: the output stage is empty or being transferred
    logic en;
    logic [LAT-1:0] valid_reg;

    assign m_valid = valid_reg[LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    // seed: magic constant minus arithmetic shift of the raw bits
    fp32_t seed;
    assign seed = SEED_MAGIC - {s_operand_bits[31], s_operand_bits[31:1]};

    fp32_t front_x_reg [MUL_LAT];
    fp32_t front_y_reg [MUL_LAT];
    fp32_t h_val;

    always_ff @(posedge aclk) begin
        if (en) begin
            front_x_reg[0] <= s_operand_bits;
            front_y_reg[0] <= seed;
            for (int i = 1; i < MUL_LAT; i++) begin
                front_x_reg[i] <= front_x_reg[i-1];
                front_y_reg[i] <= front_y_reg[i-1];
            end
        end
    end

    // h = x * 0.5 runs alongside the seed delay
    ffs_fmul u_half (.aclk(aclk), .en(en), .a(s_operand_bits), .b(HALF), .y(h_val));

    // chain of refinement cells, each handing x, h and y to the next
    fp32_t x_chain [NEWTON_STEPS+1];
    fp32_t h_chain [NEWTON_STEPS+1];
    fp32_t y_chain [NEWTON_STEPS+1];

    assign x_chain[0] = front_x_reg[MUL_LAT-1];
    assign h_chain[0] = h_val;
    assign y_chain[0] = front_y_reg[MUL_LAT-1];

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_cell
        ffs_newton_cell u_cell (
            .aclk (aclk),
            .en   (en),
            .x_in (x_chain[k]),
            .h_in (h_chain[k]),
            .y_in (y_chain[k]),
            .x_out(x_chain[k+1]),
            .h_out(h_chain[k+1]),
            .y_out(y_chain[k+1])
        );
    end

    // final product x * y lands in the output register
    ffs_fmul u_final (
        .aclk(aclk),
        .en  (en),
        .a   (x_chain[NEWTON_STEPS]),
        .b   (y_chain[NEWTON_STEPS]),
        .y   (m_root_bits)
    );

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result freezes the valid flag of every stage of the pipe
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(valid_reg))
        else $error("pipe moved during output stall");

    // no new transfer is taken while the output is stalled
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

    // an accepted operand enters the first pipe slot
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted operand lost");

endmodule

### tb/fast_float_sqrt_tb.sv
`timescale 1ns / 1ps

module fast_float_sqrt_tb;
    import ffs_pkg::*;

    localparam int NUM_RANDOM = 1130;
    localparam int DRAIN_CYCLES = 6 + 12 * 2 + 20;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_operand_bits;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_root_bits;

    fp32_t pending_operands[$];   // operands not yet offered to the block
    fp32_t expected_roots[$];     // predicted roots, oldest first
    int    error_count;
    bit    sender_paused;
    bit    receiver_hold;
    int    send_gap;
    int    recv_gap;

    fast_float_sqrt i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operand_bits (s_operand_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_root_bits    (m_root_bits)
    );

    // clock and the single reset pulse
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // binary32 arithmetic, round to nearest even, gradual underflow
    // ------------------------------------------------------------------

    function automatic bit is_nan(fp32_t a);
        return a[30:23] == 8'hff && a[22:0] != 0;
    endfunction

    function automatic bit is_inf(fp32_t a);
        return a[30:23] == 8'hff && a[22:0] == 0;
    endfunction

    function automatic bit is_zero(fp32_t a);
        return a[30:0] == 0;
    endfunction

    // value = mag * 2^scale, rounded into a binary32 with sign s
    function automatic fp32_t round_pack(bit s, int scale, logic [63:0] mag);
        int          lz;
        int          biased;
        int          shift;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half_ulp;
        logic [63:0] packed_mag;
        bit          up;
        if (mag == 0) return {s, 31'd0};
        lz = 0;
        while (!mag[63]) begin
            mag = mag << 1;
            lz++;
        end
        biased = scale - lz + 63 + 127;
        if (biased >= 255) return {s, 8'hff, 23'd0};
        // 24 significant bits stay, subnormals lose extra bits at the bottom
        shift = 40 + ((biased < 1) ? (1 - biased) : 0);
        if (shift > 64) begin
            q  = 0;
            up = 1'b0;
        end else if (shift == 64) begin
            q  = 0;
            up = mag > 64'h8000_0000_0000_0000;
        end else begin
            q        = mag >> shift;
            rem      = mag & ((64'd1 << shift) - 1);
            half_ulp = 64'd1 << (shift - 1);
            up       = (rem > half_ulp) || (rem == half_ulp && q[0]);
        end
        q = q + up;
        // implicit bit folds into the exponent field, carries included
        if (biased < 1) packed_mag = q;
        else packed_mag = (64'(biased - 1) << 23) + q;
        if (packed_mag >= 64'h7f80_0000) return {s, 8'hff, 23'd0};
        return {s, packed_mag[30:0]};
    endfunction

    function automatic void unpack(fp32_t a, output logic [23:0] mant, output int expo);
        if (a[30:23] == 0) begin
            mant = {1'b0, a[22:0]};
            expo = 1 - 127 - 23;
        end else begin
            mant = {1'b1, a[22:0]};
            expo = int'(a[30:23]) - 127 - 23;
        end
    endfunction

    function automatic fp32_t fp_mul(fp32_t a, fp32_t b);
        logic [23:0] ma, mb;
        int          ea, eb;
        bit          s;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
        unpack(a, ma, ea);
        unpack(b, mb, eb);
        return round_pack(s, ea + eb, 64'(ma) * 64'(mb));
    endfunction

    function automatic fp32_t fp_sub(fp32_t a, fp32_t b);
        fp32_t       nb;
        logic [23:0] ma, mb;
        int          ea, eb, diff;
        logic [63:0] wa, wb, lost;
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        nb = b ^ 32'h8000_0000;
        if (is_inf(a) && is_inf(nb)) begin
            if (a[31] != nb[31]) return DEFAULT_NAN;
            return a;
        end
        if (is_inf(a)) return a;
        if (is_inf(nb)) return nb;
        if (is_zero(a) && is_zero(nb)) return {a[31] & nb[31], 31'd0};
        unpack(a, ma, ea);
        unpack(nb, mb, eb);
        wa = 64'(ma) << 38;
        wb = 64'(mb) << 38;
        // align the smaller exponent, folding lost bits into a sticky bit
        if (ea < eb) begin
            diff = eb - ea;
            if (diff > 62) begin
                lost = wa;
                wa   = 0;
            end else begin
                lost = wa & ((64'd1 << diff) - 1);
                wa   = wa >> diff;
            end
            wa[0] = wa[0] | (lost != 0);
            ea    = eb;
        end else if (eb < ea) begin
            diff = ea - eb;
            if (diff > 62) begin
                lost = wb;
                wb   = 0;
            end else begin
                lost = wb & ((64'd1 << diff) - 1);
                wb   = wb >> diff;
            end
            wb[0] = wb[0] | (lost != 0);
        end
        if (a[31] == nb[31]) return round_pack(a[31], ea - 38, wa + wb);
        if (wa == wb) return 32'd0;
        if (wa > wb) return round_pack(a[31], ea - 38, wa - wb);
        return round_pack(nb[31], ea - 38, wb - wa);
    endfunction

    // seed from the integer trick, two newton refinements, then x * (1/sqrt(x))
    function automatic fp32_t predict_root(fp32_t x);
        fp32_t h, y, t;
        h = fp_mul(x, HALF);
        y = SEED_MAGIC - {x[31], x[31:1]};
        for (int k = 0; k < 2; k++) begin
            t = fp_mul(h, y);
            t = fp_mul(t, y);
            t = fp_sub(THREE_HALVES, t);
            y = fp_mul(y, t);
        end
        return fp_mul(x, y);
    endfunction

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic fp32_t random_operand();
        int roll;
        roll = $urandom_range(99);
        // raw patterns cover nan, inf, negatives; positive cases stress roots
        if (roll < 40) return $urandom;
        if (roll < 80) return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
        if (roll < 90) return {1'b0, 8'd0, 23'($urandom)};
        if (roll < 95) return {1'b0, 8'($urandom_range(140, 110)), 23'($urandom)};
        return {1'b1, 8'($urandom_range(254, 0)), 23'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued operands, records a prediction per transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_operand_bits <= '0;
            send_gap       <= 0;
        end else begin
            if (s_valid && s_ready) expected_roots.push_back(predict_root(s_operand_bits));
            // valid stays up with a stable payload until the transfer happens
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_operands.size() > 0 && !sender_paused) begin
                    s_operand_bits <= pending_operands.pop_front();
                    s_valid        <= 1'b1;
                    send_gap       <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure and in-order compare of every root
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        fp32_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_roots.size() == 0) begin
                    $display("%0t: unexpected root %h with nothing pending", $time,
                             m_root_bits);
                    error_count++;
                end else begin
                    want = expected_roots.pop_front();
                    if (m_root_bits !== want) begin
                        $display("%0t: root_bits mismatch expected %h actual %h", $time,
                                 want, m_root_bits);
                        error_count++;
                    end
                end
            end
            if (receiver_hold) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // long receiver hold-off so the pipe fills and s_ready drops
    initial begin
        receiver_hold = 1'b0;
        wait (aresetn);
        repeat (60) @(posedge aclk);
        receiver_hold = 1'b1;
        repeat (200) @(posedge aclk);
        receiver_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        error_count   = 0;
        sender_paused = 1'b0;
        // directed corners: zeros, infinities, nans, subnormal and normal limits
        pending_operands.push_back(32'h0000_0000);
        pending_operands.push_back(32'h8000_0000);
        pending_operands.push_back(32'h7f80_0000);
        pending_operands.push_back(32'hff80_0000);
        pending_operands.push_back(32'h7fc0_0000);
        pending_operands.push_back(32'h7f80_0001);
        pending_operands.push_back(32'hffc0_1234);
        pending_operands.push_back(32'h7fff_ffff);
        pending_operands.push_back(32'hffff_ffff);
        pending_operands.push_back(32'h0000_0001);
        pending_operands.push_back(32'h0000_0002);
        pending_operands.push_back(32'h007f_ffff);
        pending_operands.push_back(32'h0080_0000);
        pending_operands.push_back(32'h7f7f_ffff);
        pending_operands.push_back(32'h3f80_0000);
        pending_operands.push_back(32'h4000_0000);
        pending_operands.push_back(32'h4080_0000);
        pending_operands.push_back(32'hbf80_0000);
        pending_operands.push_back(32'h8000_0001);
        pending_operands.push_back(32'h5f37_59df);
        pending_operands.push_back(32'haaaa_aaaa);
        pending_operands.push_back(32'h5555_5555);
        for (int i = 0; i < NUM_RANDOM / 2; i++) pending_operands.push_back(random_operand());

        // sender pauses until the block has drained completely
        wait (aresetn);
        while (pending_operands.size() > 0 || s_valid) @(posedge aclk);
        sender_paused = 1'b1;
        while (expected_roots.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        sender_paused = 1'b0;

        for (int i = NUM_RANDOM / 2; i < NUM_RANDOM; i++)
            pending_operands.push_back(random_operand());
        while (pending_operands.size() > 0 || s_valid) @(posedge aclk);
        while (expected_roots.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_roots.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
